FILE: sv/sbs_pkg.sv
// Shared types and constants for the submatrix block swap engine.
`default_nettype none

package sbs_pkg;

	// Size registers are 5 bits wide, so a clamped dimension always fits in 5 bits
	localparam int DIM_W  = 5;
	localparam int SIZE_W = 2 * DIM_W;
	localparam int VAL_W  = 16;

	typedef logic [DIM_W-1:0]  dim_t;
	typedef logic [SIZE_W-1:0] size_t;

	// Item opcodes
	typedef enum logic [2:0] {
		MODE_WR_A = 3'd0,
		MODE_WR_B = 3'd1,
		MODE_SWAP = 3'd2,
		MODE_RD_A = 3'd3,
		MODE_RD_B = 3'd4
	} mode_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_OFFSET = 2'd1,
		ST_INDEX  = 2'd2
	} status_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_ROWS_A = 2'd0,
		CFG_COLS_A = 2'd1,
		CFG_ROWS_B = 2'd2,
		CFG_COLS_B = 2'd3
	} cfg_idx_t;

	// Engine sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_WALK,
		S_DRAIN,
		S_RDWAIT,
		S_FINISH
	} state_t;

	// Clamped matrix dimensions and element counts
	typedef struct packed {
		dim_t  ra;
		dim_t  ca;
		dim_t  rb;
		dim_t  cb;
		size_t size_a;
		size_t size_b;
	} dims_t;

endpackage

`default_nettype wire

FILE: sv/sbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: sv/sbs_cfg.sv
// Size registers, dimension clamping and element counts.
`default_nettype none

module sbs_cfg #(
	parameter int MAX_DIM = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [4:0]    cfg_data,
	output sbs_pkg::dims_t     dims
);

	sbs_pkg::dim_t rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	sbs_pkg::dim_t ra, ca, rb, cb;

	// Zero counts as one, anything above the maximum as the maximum
	function automatic sbs_pkg::dim_t clamp_dim(input sbs_pkg::dim_t v);
		if (v == sbs_pkg::dim_t'(0)) begin
			return sbs_pkg::dim_t'(1);
		end else if (int'(v) > MAX_DIM) begin
			return sbs_pkg::dim_t'(MAX_DIM);
		end
		return v;
	endfunction

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= sbs_pkg::dim_t'(1);
			cols_a_q <= sbs_pkg::dim_t'(1);
			rows_b_q <= sbs_pkg::dim_t'(1);
			cols_b_q <= sbs_pkg::dim_t'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (sbs_pkg::cfg_idx_t'(cfg_index))
				sbs_pkg::CFG_ROWS_A: rows_a_q <= cfg_data;
				sbs_pkg::CFG_COLS_A: cols_a_q <= cfg_data;
				sbs_pkg::CFG_ROWS_B: rows_b_q <= cfg_data;
				sbs_pkg::CFG_COLS_B: cols_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective sizes
	always_comb begin
		ra = clamp_dim(rows_a_q);
		ca = clamp_dim(cols_a_q);
		rb = clamp_dim(rows_b_q);
		cb = clamp_dim(cols_b_q);
		dims.ra = ra;
		dims.ca = ca;
		dims.rb = rb;
		dims.cb = cb;
		dims.size_a = {{sbs_pkg::DIM_W{1'b0}}, ra} * {{sbs_pkg::DIM_W{1'b0}}, ca};
		dims.size_b = {{sbs_pkg::DIM_W{1'b0}}, rb} * {{sbs_pkg::DIM_W{1'b0}}, cb};
	end

endmodule

`default_nettype wire

FILE: sv/sbs_engine.sv
// Item sequencer: element reads and writes, and the block swap walk over two RAMs.
`default_nettype none

module sbs_engine #(
	parameter int MAX_DIM    = 16,
	parameter int ELEM_WIDTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sbs_pkg::dims_t      dims,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [2:0]          mode,
	input  wire logic [7:0]          flat_index,
	input  wire logic signed [15:0]  element_value,
	input  wire logic [3:0]          row_offset,
	input  wire logic [3:0]          col_offset,
	output logic                     res_valid,
	input  wire logic                res_take,
	output logic signed [15:0]       res_value,
	output sbs_pkg::status_t         res_status
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = sbs_pkg::DIM_W;
	localparam int SW    = sbs_pkg::SIZE_W;

	sbs_pkg::state_t  state_q, state_d;
	sbs_pkg::mode_t   mode_in, mode_q;

	// Placement registers
	sbs_pkg::dim_t    ora_q, orb_q, oca_q, ocb_q, nr_q, nc_q;
	logic             place_ok_q;

	// Walk registers
	sbs_pkg::dim_t    row_q, col_q;
	sbs_pkg::size_t   base_a_q, base_b_q;
	logic             vld_s1;
	logic [AW-1:0]    ia_s1, ib_s1;

	// Result registers
	logic signed [15:0] res_value_q;
	sbs_pkg::status_t   res_status_q;

	// Combinational helpers
	logic             on_a, idx_ok, accept, last_pair, col_last;
	sbs_pkg::size_t   size_sel;
	logic             r_gt_a, r_gt_b, c_gt_a, c_gt_b, r_ok, c_ok;
	sbs_pkg::dim_t    r_slack, c_slack, roff, coff;
	sbs_pkg::size_t   prod_a, prod_b, walk_a, walk_b;

	// RAM ports
	logic                  we_a, we_b;
	logic [AW-1:0]         waddr_a, waddr_b, raddr_a, raddr_b;
	logic [ELEM_WIDTH-1:0] wdata_a, wdata_b, rdata_a, rdata_b;

	sbs_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr_a),
		.wdata (wdata_a),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	sbs_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr_b),
		.wdata (wdata_b),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	assign mode_in  = sbs_pkg::mode_t'(mode);
	assign in_ready = (state_q == sbs_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;

	// Index check against the addressed matrix
	always_comb begin
		on_a     = (mode_in == sbs_pkg::MODE_WR_A) || (mode_in == sbs_pkg::MODE_RD_A);
		size_sel = on_a ? dims.size_a : dims.size_b;
		idx_ok   = {{(SW - 8){1'b0}}, flat_index} < size_sel;
	end

	// Block placement per dimension: larger side takes the offset
	always_comb begin
		roff    = {1'b0, row_offset};
		coff    = {1'b0, col_offset};
		r_gt_a  = dims.ra > dims.rb;
		r_gt_b  = dims.rb > dims.ra;
		c_gt_a  = dims.ca > dims.cb;
		c_gt_b  = dims.cb > dims.ca;
		r_slack = r_gt_a ? dims.ra - dims.rb : dims.rb - dims.ra;
		c_slack = c_gt_a ? dims.ca - dims.cb : dims.cb - dims.ca;
		r_ok    = !(r_gt_a || r_gt_b) || (roff <= r_slack);
		c_ok    = !(c_gt_a || c_gt_b) || (coff <= c_slack);
	end

	// Walk addresses and end conditions
	always_comb begin
		prod_a    = {{DW{1'b0}}, ora_q} * {{DW{1'b0}}, dims.ca};
		prod_b    = {{DW{1'b0}}, orb_q} * {{DW{1'b0}}, dims.cb};
		walk_a    = base_a_q + {{DW{1'b0}}, col_q};
		walk_b    = base_b_q + {{DW{1'b0}}, col_q};
		col_last  = (col_q == nc_q - sbs_pkg::dim_t'(1));
		last_pair = col_last && (row_q == nr_q - sbs_pkg::dim_t'(1));
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sbs_pkg::S_IDLE: begin
				if (accept) begin
					case (mode_in)
						sbs_pkg::MODE_SWAP: state_d = sbs_pkg::S_SETUP;
						sbs_pkg::MODE_RD_A,
						sbs_pkg::MODE_RD_B: state_d = idx_ok ? sbs_pkg::S_RDWAIT
						                                     : sbs_pkg::S_FINISH;
						default:            state_d = sbs_pkg::S_FINISH;
					endcase
				end
			end
			sbs_pkg::S_SETUP:  state_d = place_ok_q ? sbs_pkg::S_WALK : sbs_pkg::S_FINISH;
			sbs_pkg::S_WALK:   state_d = last_pair ? sbs_pkg::S_DRAIN : sbs_pkg::S_WALK;
			sbs_pkg::S_DRAIN:  state_d = sbs_pkg::S_FINISH;
			sbs_pkg::S_RDWAIT: state_d = sbs_pkg::S_FINISH;
			sbs_pkg::S_FINISH: state_d = res_take ? sbs_pkg::S_IDLE : sbs_pkg::S_FINISH;
			default:           state_d = sbs_pkg::S_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		we_a    = 1'b0;
		we_b    = 1'b0;
		waddr_a = AW'(flat_index);
		waddr_b = AW'(flat_index);
		wdata_a = ELEM_WIDTH'(element_value);
		wdata_b = ELEM_WIDTH'(element_value);
		raddr_a = AW'(flat_index);
		raddr_b = AW'(flat_index);
		case (state_q)
			sbs_pkg::S_IDLE: begin
				if (accept && idx_ok) begin
					we_a = (mode_in == sbs_pkg::MODE_WR_A);
					we_b = (mode_in == sbs_pkg::MODE_WR_B);
				end
			end
			sbs_pkg::S_WALK: begin
				raddr_a = AW'(walk_a);
				raddr_b = AW'(walk_b);
			end
			default: ;
		endcase
		// Swap write-back follows the reads in the next cycle
		if (vld_s1) begin
			we_a    = 1'b1;
			we_b    = 1'b1;
			waddr_a = ia_s1;
			waddr_b = ib_s1;
			wdata_a = rdata_b;
			wdata_b = rdata_a;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbs_pkg::S_IDLE;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == sbs_pkg::S_WALK);
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		ia_s1 <= AW'(walk_a);
		ib_s1 <= AW'(walk_b);
		case (state_q)
			sbs_pkg::S_IDLE: begin
				if (accept) begin
					mode_q       <= mode_in;
					ora_q        <= r_gt_a ? roff : sbs_pkg::dim_t'(0);
					orb_q        <= r_gt_b ? roff : sbs_pkg::dim_t'(0);
					oca_q        <= c_gt_a ? coff : sbs_pkg::dim_t'(0);
					ocb_q        <= c_gt_b ? coff : sbs_pkg::dim_t'(0);
					nr_q         <= r_gt_a ? dims.rb : dims.ra;
					nc_q         <= c_gt_a ? dims.cb : dims.ca;
					place_ok_q   <= r_ok && c_ok;
					res_value_q  <= '0;
					res_status_q <= sbs_pkg::ST_OK;
					case (mode_in)
						sbs_pkg::MODE_WR_A, sbs_pkg::MODE_WR_B,
						sbs_pkg::MODE_RD_A, sbs_pkg::MODE_RD_B: begin
							if (!idx_ok) begin
								res_status_q <= sbs_pkg::ST_INDEX;
							end
						end
						default: ;
					endcase
				end
			end
			sbs_pkg::S_SETUP: begin
				base_a_q <= prod_a + {{DW{1'b0}}, oca_q};
				base_b_q <= prod_b + {{DW{1'b0}}, ocb_q};
				row_q    <= '0;
				col_q    <= '0;
				if (!place_ok_q) begin
					res_status_q <= sbs_pkg::ST_OFFSET;
				end
			end
			sbs_pkg::S_WALK: begin
				if (col_last) begin
					col_q    <= '0;
					row_q    <= row_q + sbs_pkg::dim_t'(1);
					base_a_q <= base_a_q + {{DW{1'b0}}, dims.ca};
					base_b_q <= base_b_q + {{DW{1'b0}}, dims.cb};
				end else begin
					col_q <= col_q + sbs_pkg::dim_t'(1);
				end
			end
			sbs_pkg::S_RDWAIT: begin
				if (mode_q == sbs_pkg::MODE_RD_A) begin
					res_value_q <= 16'($signed(rdata_a));
				end else begin
					res_value_q <= 16'($signed(rdata_b));
				end
			end
			default: ;
		endcase
	end

	assign res_valid  = (state_q == sbs_pkg::S_FINISH);
	assign res_value  = res_value_q;
	assign res_status = res_status_q;

endmodule

`default_nettype wire

FILE: sv/submatrix_block_swap_top.sv
// Top level of the submatrix block swap: size registers, engine and result register.
//
//  Channel  Handshake               Payload
//  -------  ----------------------  ----------------------------------------------------
//  cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//  in       in_valid / in_ready     mode, flat_index, element_value, row_offset, col_offset
//  out      out_valid / out_ready   read_value, status
//
//  Writes, index errors and unused modes go straight to the result state; element reads
//  wait for one RAM read first, and swaps rejected for their offsets pass a setup state.
//  A swap passes setup, walk and drain states: the walk moves one element pair per cycle
//  through the read and write ports of the two matrix RAMs, up to MAX_DIM*MAX_DIM pairs.
//  One item is in work at a time; a finished result waits in the output register
//  while the next item is taken. Reset sets all sizes to 1; RAM contents are not cleared.
`default_nettype none

module submatrix_block_swap_top #(
	parameter int MAX_DIM    = 16,
	parameter int ELEM_WIDTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [4:0]         cfg_data,
	// items
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         mode,
	input  wire logic [7:0]         flat_index,
	input  wire logic signed [15:0] element_value,
	input  wire logic [3:0]         row_offset,
	input  wire logic [3:0]         col_offset,
	// results
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      read_value,
	output logic [1:0]              status
);

	sbs_pkg::dims_t     dims;
	logic               res_valid, res_take;
	logic signed [15:0] res_value;
	sbs_pkg::status_t   res_status;

	logic               out_valid_q;
	logic signed [15:0] read_value_q;
	sbs_pkg::status_t   status_q;

	sbs_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dims      (dims)
	);

	sbs_engine #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.dims          (dims),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.flat_index    (flat_index),
		.element_value (element_value),
		.row_offset    (row_offset),
		.col_offset    (col_offset),
		.res_valid     (res_valid),
		.res_take      (res_take),
		.res_value     (res_value),
		.res_status    (res_status)
	);

	// Result moves into the output register when it is empty or draining
	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output beat payload
	always_ff @(posedge clk) begin
		if (res_take) begin
			read_value_q <= res_value;
			status_q     <= res_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

endmodule

`default_nettype wire
